// ===== sv/dll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_pkg
// item types, operation codes and status codes for the linked list engine
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int MODE_W = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 6;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_END    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AFTER  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BEFORE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FOUND    = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } dll_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } dll_out_t;

endpackage

// ===== sv/doubly_linked_list_engine.sv =====
`timescale 1ns / 1ps
// front/end insert: fill the taken slot, then link it; keyed insert walks from the head,
//   then fills and links; delete walks, then links; search only walks to the match
// a refused front/end insert, a keyed item on an empty list or a spare code answers from idle,
//   a missing key once the walk has passed every node, a refused keyed insert after its walk
// results cannot be held off; a new item may start in the cycle done_o shows a result
// reset empties the list and frees every slot; node memories are not cleared
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// ordered list of values in a fixed pool of doubly linked nodes kept in memory
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
  parameter int MAX_NODES  = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  dll_pkg::dll_in_t item_i,
  output logic             busy,
  output logic             done_o,
  output dll_pkg::dll_out_t result_o
);
  import dll_pkg::*;

  // slot address width, and index width that also holds the null index
  localparam int AW = $clog2(MAX_NODES);
  localparam int IW = $clog2(MAX_NODES + 1);
  // values are kept and compared in their low bits only
  localparam int SW = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
  localparam logic [IW-1:0] NIL = IW'(MAX_NODES);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;
  localparam logic [1:0] S_LINK = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [SW-1:0]        key_q, key_d;
  logic [SW-1:0]        val_q, val_d;
  logic [IW-1:0]        cur_q, cur_d;   // node being compared during the walk
  logic [IW-1:0]        pos_q, pos_d;   // 1-based place of cur_q
  logic [IW-1:0]        p_q, p_d;       // node before the splice point
  logic [IW-1:0]        q_q, q_d;       // node after the splice point
  logic [IW-1:0]        n_q, n_d;       // freshly taken slot
  logic [IW-1:0]        ln_q, ln_d;     // goes into next link of p, or head
  logic [IW-1:0]        lp_q, lp_d;     // goes into prev link of q, or tail
  logic [IW-1:0]        head_q, head_d;
  logic [IW-1:0]        tail_q, tail_d;
  logic [MAX_NODES-1:0] free_q, free_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic                 done_q, done_d;
  dll_out_t             result_q, result_d;

  // node memories, one write and one registered read port each
  logic [SW-1:0] val_mem [MAX_NODES];
  logic [IW-1:0] nxt_mem [MAX_NODES];
  logic [IW-1:0] prv_mem [MAX_NODES];

  logic [AW-1:0] rd_addr;
  logic [SW-1:0] val_rd_q;
  logic [IW-1:0] nxt_rd_q;
  logic [IW-1:0] prv_rd_q;

  logic          val_we, nxt_we, prv_we;
  logic [AW-1:0] val_wa, nxt_wa, prv_wa;
  logic [SW-1:0] val_wd;
  logic [IW-1:0] nxt_wd, prv_wd;

  logic              full;
  logic [AW-1:0]     free_idx;
  logic              fin;
  logic [STAT_W-1:0] fin_st;

  assign full = ~|free_q;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    key_d    = key_q;
    val_d    = val_q;
    cur_d    = cur_q;
    pos_d    = pos_q;
    p_d      = p_q;
    q_d      = q_q;
    n_d      = n_q;
    ln_d     = ln_q;
    lp_d     = lp_q;
    head_d   = head_q;
    tail_d   = tail_q;
    free_d   = free_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    result_d = result_q;
    fin      = 1'b0;
    fin_st   = ST_DONE;
    rd_addr  = cur_q[AW-1:0];
    val_we   = 1'b0;
    val_wa   = n_q[AW-1:0];
    val_wd   = val_q;
    nxt_we   = 1'b0;
    nxt_wa   = n_q[AW-1:0];
    nxt_wd   = q_q;
    prv_we   = 1'b0;
    prv_wa   = n_q[AW-1:0];
    prv_wd   = p_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d = item_i.mode;
          key_d  = item_i.key[SW-1:0];
          val_d  = item_i.value[SW-1:0];
          case (item_i.mode)
            MODE_FRONT, MODE_END: begin
              if (full) begin
                fin    = 1'b1;
                fin_st = ST_FULL;
              end else begin
                n_d    = IW'(free_idx);
                ln_d   = IW'(free_idx);
                lp_d   = IW'(free_idx);
                p_d    = (item_i.mode == MODE_END) ? tail_q : NIL;
                q_d    = (item_i.mode == MODE_FRONT) ? head_q : NIL;
                free_d[free_idx] = 1'b0;
                cnt_d  = cnt_q + IW'(1);
                state_d = S_FILL;
              end
            end
            MODE_AFTER, MODE_BEFORE, MODE_DEL, MODE_SEARCH: begin
              if (head_q == NIL) begin
                fin    = 1'b1;
                fin_st = ST_NOTFOUND;
              end else begin
                // start the walk at the head
                rd_addr = head_q[AW-1:0];
                cur_d   = head_q;
                pos_d   = IW'(1);
                state_d = S_WALK;
              end
            end
            default: begin
              fin    = 1'b1;
              fin_st = ST_DONE;
            end
          endcase
        end
      end

      S_WALK: begin
        if (val_rd_q == key_q) begin
          case (mode_q)
            MODE_SEARCH: begin
              fin    = 1'b1;
              fin_st = ST_FOUND;
            end
            MODE_DEL: begin
              // unlink cur_q: prev gets its next, next gets its prev
              p_d  = prv_rd_q;
              q_d  = nxt_rd_q;
              ln_d = nxt_rd_q;
              lp_d = prv_rd_q;
              free_d[cur_q[AW-1:0]] = 1'b1;
              cnt_d   = cnt_q - IW'(1);
              state_d = S_LINK;
            end
            default: begin
              if (full) begin
                fin    = 1'b1;
                fin_st = ST_FULL;
              end else begin
                n_d  = IW'(free_idx);
                ln_d = IW'(free_idx);
                lp_d = IW'(free_idx);
                if (mode_q == MODE_AFTER) begin
                  p_d = cur_q;
                  q_d = nxt_rd_q;
                end else begin
                  p_d = prv_rd_q;
                  q_d = cur_q;
                end
                free_d[free_idx] = 1'b0;
                cnt_d   = cnt_q + IW'(1);
                state_d = S_FILL;
              end
            end
          endcase
        end else if (nxt_rd_q == NIL) begin
          fin    = 1'b1;
          fin_st = ST_NOTFOUND;
        end else begin
          rd_addr = nxt_rd_q[AW-1:0];
          cur_d   = nxt_rd_q;
          pos_d   = pos_q + IW'(1);
        end
      end

      S_FILL: begin
        // new node gets its value and both links
        val_we  = 1'b1;
        nxt_we  = 1'b1;
        prv_we  = 1'b1;
        state_d = S_LINK;
      end

      S_LINK: begin
        // neighbours point at each other, or head and tail move
        if (p_q != NIL) begin
          nxt_we = 1'b1;
          nxt_wa = p_q[AW-1:0];
          nxt_wd = ln_q;
        end else begin
          head_d = ln_q;
        end
        if (q_q != NIL) begin
          prv_we = 1'b1;
          prv_wa = q_q[AW-1:0];
          prv_wd = lp_q;
        end else begin
          tail_d = lp_q;
        end
        fin    = 1'b1;
        fin_st = ST_DONE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      done_d            = 1'b1;
      result_d.status   = fin_st;
      result_d.position = (fin_st == ST_FOUND) ? POS_W'(pos_q) : '0;
      result_d.count    = CNT_W'(cnt_d);
      state_d           = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NIL;
      tail_q  <= NIL;
      free_q  <= '1;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    key_q    <= key_d;
    val_q    <= val_d;
    cur_q    <= cur_d;
    pos_q    <= pos_d;
    p_q      <= p_d;
    q_q      <= q_d;
    n_q      <= n_d;
    ln_q     <= ln_d;
    lp_q     <= lp_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_rd_q <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    prv_rd_q <= prv_mem[rd_addr];
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // every slot is either on the list or free
  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(free_q)) + 32'(cnt_q) == 32'(MAX_NODES))
    else $error("slot count and free mask disagree");

  // at rest the list is empty exactly when the head is null
  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> (head_q == NIL) == (cnt_q == '0))
    else $error("head and entry count disagree");

  // a result only appears once the controller is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe while busy");

  // an accepted item either finishes at once or keeps the block busy
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_q)
    else $error("accepted item lost");

  // a refused insert leaves the pool full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && result_q.status == ST_FULL |-> free_q == '0)
    else $error("insert refused with a free slot");

endmodule

// ===== tb/sv/doubly_linked_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_tb
// self-checking bench for the linked list engine: a queue-based shadow list
// predicts status, position and count for every item accepted on the start
// handshake, and a monitor compares each done_o strobe against the oldest
// prediction; directed corner items first, then phased random traffic
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_tb;

  import dll_pkg::*;

  localparam int POOL_SLOTS     = 32;
  localparam int RANDOM_ITEMS   = 600;
  localparam int PHASE_LEN      = 45;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  // the two spare operation codes, which leave the list alone
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // traffic phases of the random part
  localparam int PH_FILL  = 0;
  localparam int PH_MIXED = 1;
  localparam int PH_DRAIN = 2;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  dll_in_t  item_i = '0;
  logic     busy;
  logic     done_o;
  dll_out_t result_o;

  dll_in_t                  item_q[$];      // items waiting to be driven
  dll_out_t                 result_q[$];    // predicted results, oldest first
  logic signed [DATA_W-1:0] shadow_list[$]; // list contents, head first

  int accepted_cnt = 0;
  int fail_cnt     = 0;
  int stall_cnt    = 0;

  always #4 clk_i = ~clk_i;

  doubly_linked_list_engine #(
    .MAX_NODES  (POOL_SLOTS),
    .VALUE_BITS (DATA_W)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // applies one operation to the shadow list and returns what the engine
  // should answer; a keyed operation looks for the first match from the head
  function automatic dll_out_t apply_list_op(input dll_in_t op);
    dll_out_t res;
    int       hit;
    bit       full;
    res  = '0;
    hit  = -1;
    full = (shadow_list.size() >= POOL_SLOTS);
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (hit < 0 && shadow_list[i] == op.key) hit = i;
    end
    res.status = ST_DONE;
    case (op.mode)
      MODE_FRONT: begin
        if (full) res.status = ST_FULL;
        else shadow_list.push_front(op.value);
      end
      MODE_END: begin
        if (full) res.status = ST_FULL;
        else shadow_list.push_back(op.value);
      end
      // missing key wins over a full pool
      MODE_AFTER: begin
        if (hit < 0) res.status = ST_NOTFOUND;
        else if (full) res.status = ST_FULL;
        else shadow_list.insert(hit + 1, op.value);
      end
      MODE_BEFORE: begin
        if (hit < 0) res.status = ST_NOTFOUND;
        else if (full) res.status = ST_FULL;
        else shadow_list.insert(hit, op.value);
      end
      MODE_DEL: begin
        if (hit < 0) res.status = ST_NOTFOUND;
        else shadow_list.delete(hit);
      end
      MODE_SEARCH: begin
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.status   = ST_FOUND;
          res.position = POS_W'(hit + 1);
        end
      end
      default: begin
        // spare codes: nothing changes
      end
    endcase
    res.count = CNT_W'(shadow_list.size());
    return res;
  endfunction

  function automatic dll_in_t mk_item(input logic [MODE_W-1:0] m,
                                      input logic signed [DATA_W-1:0] k,
                                      input logic signed [DATA_W-1:0] v);
    dll_in_t it;
    it.mode  = m;
    it.key   = k;
    it.value = v;
    return it;
  endfunction

  // driver: an item is taken at an edge with start high and busy low; the
  // prediction is made right there so it always runs ahead of done_o
  always @(posedge clk_i) begin : drive_proc
    dll_in_t taken;
    bit      hold_off;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      // no gaps at all for a stretch in the middle of the run
      hold_off = !(accepted_cnt >= 250 && accepted_cnt < 350) &&
                 ($urandom_range(0, 99) < 36);
      if (start && !busy) begin
        taken = item_q.pop_front();
        result_q.push_back(apply_list_op(taken));
        accepted_cnt++;
      end
      // a start not yet taken stays up with the same item
      if (!(start && busy)) begin
        if (item_q.size() != 0 && !hold_off) begin
          start  <= 1'b1;
          item_i <= item_q[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe must match the oldest prediction field by field
  always @(posedge clk_i) begin : check_proc
    dll_out_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d position %0d count %0d",
               result_o.status, result_o.position, result_o.count);
        fail_cnt++;
      end else begin
        want = result_q.pop_front();
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_o.status);
          fail_cnt++;
        end
        if (result_o.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, result_o.position);
          fail_cnt++;
        end
        if (result_o.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, result_o.count);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: too long with neither an item taken nor a result seen
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("doubly_linked_list_engine_tb: done, errors");
      $finish;
    end
  end

  initial begin : stim_proc
    dll_in_t                  it;
    int                       phase;
    int                       r;
    int                       m;
    int                       cut[6];
    logic signed [DATA_W-1:0] pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: keyed operations all miss, spare codes do nothing
    item_q.push_back(mk_item(MODE_DEL,    32'sd0, 32'sd0));
    item_q.push_back(mk_item(MODE_SEARCH, 32'sd0, 32'sd0));
    item_q.push_back(mk_item(MODE_AFTER,  32'sd0, 32'sd1));
    item_q.push_back(mk_item(MODE_BEFORE, 32'sd0, 32'sd1));
    item_q.push_back(mk_item(MODE_SPARE6, VAL_MAX, VAL_MIN));
    item_q.push_back(mk_item(MODE_SPARE7, VAL_MIN, VAL_MAX));
    // build with extreme values at both ends
    item_q.push_back(mk_item(MODE_FRONT,  32'sd0,  VAL_MIN));
    item_q.push_back(mk_item(MODE_END,    32'sd0,  VAL_MAX));
    item_q.push_back(mk_item(MODE_FRONT,  32'sd0,  32'sd0));
    item_q.push_back(mk_item(MODE_END,    32'sd0,  -32'sd1));
    item_q.push_back(mk_item(MODE_AFTER,  VAL_MAX, 32'sd5));
    item_q.push_back(mk_item(MODE_BEFORE, VAL_MIN, -32'sd5));
    item_q.push_back(mk_item(MODE_SEARCH, VAL_MAX, 32'sd0));
    item_q.push_back(mk_item(MODE_SEARCH, -32'sd1, 32'sd0));
    item_q.push_back(mk_item(MODE_SEARCH, 32'sd123, 32'sd0));
    item_q.push_back(mk_item(MODE_AFTER,  32'sd123, 32'sd9));
    item_q.push_back(mk_item(MODE_DEL,    32'sd123, 32'sd0));
    // remove head, tail and a middle node
    item_q.push_back(mk_item(MODE_DEL,    32'sd0,  32'sd0));
    item_q.push_back(mk_item(MODE_DEL,    -32'sd1, 32'sd0));
    item_q.push_back(mk_item(MODE_DEL,    VAL_MAX, 32'sd0));
    // duplicates: the first match from the head counts
    item_q.push_back(mk_item(MODE_END,    32'sd0,  32'sd7));
    item_q.push_back(mk_item(MODE_FRONT,  32'sd0,  32'sd7));
    item_q.push_back(mk_item(MODE_SEARCH, 32'sd7,  32'sd0));
    item_q.push_back(mk_item(MODE_DEL,    32'sd7,  32'sd0));
    item_q.push_back(mk_item(MODE_SEARCH, 32'sd7,  32'sd0));

    // random part, rotating fill / mixed / drain so the pool runs full and
    // empty again; keys mostly come from the list so keyed operations hit
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // keep one item queued so the driver never runs dry between items
      while (item_q.size() > 1) @(negedge clk_i);
      phase = (n / PHASE_LEN) % 3;
      case (phase)
        PH_FILL:  cut = '{30, 55, 72, 88, 93, 98};
        PH_DRAIN: cut = '{10, 15, 20, 25, 70, 95};
        default:  cut = '{15, 30, 45, 60, 78, 96};
      endcase
      r = $urandom_range(0, 99);
      m = 0;
      while (m < 6 && r >= cut[m]) m++;
      if (m == 6) it.mode = $urandom_range(0, 1) ? MODE_SPARE7 : MODE_SPARE6;
      else it.mode = MODE_W'(m);

      pick = (shadow_list.size() != 0) ?
             shadow_list[$urandom_range(0, shadow_list.size() - 1)] : 32'sd0;
      if (shadow_list.size() != 0 && $urandom_range(0, 99) < 80) it.key = pick;
      else it.key = $urandom;

      // small values and copies of stored ones give duplicate keys
      r = $urandom_range(0, 9);
      if (r < 4) it.value = $urandom;
      else if (r < 7) it.value = $signed($urandom_range(0, 15)) - 32'sd8;
      else it.value = pick;

      item_q.push_back(it);
    end

    while (item_q.size() != 0 || result_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("doubly_linked_list_engine_tb: done, clean");
    end else begin
      $display("doubly_linked_list_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
